[hdl/sliding_window_max_top_defines.svh]
// Assertion macros shared by the checker of the sliding window maximum block.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef SLIDING_WINDOW_MAX_TOP_DEFINES_SVH
`define SLIDING_WINDOW_MAX_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWM_ASSERT_NOW(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sliding window max: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SWM_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sliding window max: next-cycle check failed");

`endif

[hdl/swm_pkg.sv]
// Shared constants and types of the sliding window maximum block.
// Depends on nothing; used by swm_cell and sliding_window_max_top.
package swm_pkg;

	localparam int DEPTH    = 64;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int CNT_W    = IDX_W + 1;
	localparam int SAMPLE_W = 32;
	localparam int POS_W    = 32;
	localparam int CFG_W    = 7;

	localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(3);

	typedef struct packed {
		logic shift;
		logic clear;
	} swm_cell_ctrl_t;

endpackage

[hdl/swm_cell.sv]
// One cell of the running-maximum chain: the maximum of the newest samples up to its age.
// Depends on swm_pkg for the sample width and the control struct.
module swm_cell (
	input  logic                                 clk,
	input  swm_pkg::swm_cell_ctrl_t              ctrl,
	input  logic signed [swm_pkg::SAMPLE_W-1:0]  sample,
	input  logic signed [swm_pkg::SAMPLE_W-1:0]  prev_max,
	output logic signed [swm_pkg::SAMPLE_W-1:0]  max_q
);
	import swm_pkg::*;

	logic take_sample;

	assign take_sample = ctrl.clear || (sample >= prev_max);

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			max_q <= take_sample ? sample : prev_max;
		end
	end

endmodule

[hdl/sliding_window_max_top.sv]
// Sliding window maximum: each result is registered and offered in the cycle after its input transfer.
// One sample is accepted per cycle unless the input is stalled; each sample moves the chain of maximum cells once.
// A sample without a result is still accepted; a held result stalls the input.
// Reset (asynchronous, active low) sets the window to 3 and empties the window.
// The cell array needs no clearing pass; it is written before it is read.
// Depends on swm_pkg and swm_cell.
module sliding_window_max_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [swm_pkg::CFG_W-1:0]            window_size,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [swm_pkg::SAMPLE_W-1:0]  sample,
	input  logic                                 restart,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [swm_pkg::SAMPLE_W-1:0]  window_max
);
	import swm_pkg::*;

	logic [CFG_W-1:0]           window_size_q;
	logic [CNT_W-1:0]           k_eff;
	logic [CNT_W-1:0]           k_m1;
	logic [CNT_W-1:0]           alive_q;
	logic [CNT_W-1:0]           alive_inc;
	logic [CNT_W-1:0]           alive_next;
	logic [CNT_W-1:0]           sel;
	logic [POS_W-1:0]           pos_q;
	logic [POS_W-1:0]           pos;
	logic                       wrapped_q;
	logic                       wrapped_next;
	logic                       emit;
	logic                       in_fire;
	logic signed [SAMPLE_W-1:0] sel_max;
	logic signed [SAMPLE_W-1:0] result;
	logic signed [SAMPLE_W-1:0] window_max_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] cell_max [DEPTH];
	swm_cell_ctrl_t             cell_ctrl [DEPTH];

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;

	always_comb begin
		if (window_size_q == '0) begin
			k_eff = CNT_W'(1);
		end else if (CNT_W'(window_size_q) > CNT_W'(DEPTH)) begin
			k_eff = CNT_W'(DEPTH);
		end else begin
			k_eff = CNT_W'(window_size_q);
		end
	end

	assign k_m1      = k_eff - CNT_W'(1);
	assign alive_inc = alive_q + CNT_W'(1);
	assign alive_next = restart ? CNT_W'(1) : ((alive_inc > k_eff) ? k_eff : alive_inc);
	assign sel       = alive_next - CNT_W'(2);
	assign sel_max   = cell_max[sel[IDX_W-1:0]];

	assign pos          = restart ? '0 : pos_q;
	assign wrapped_next = (!restart && wrapped_q) || (pos == '1);
	assign emit         = wrapped_next || (pos >= POS_W'(k_m1));

	always_comb begin
		if (alive_next == CNT_W'(1)) begin
			result = sample;
		end else if (sample >= sel_max) begin
			result = sample;
		end else begin
			result = sel_max;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			assign cell_ctrl[gi].shift = in_fire;
			if (gi == 0) begin : g_head
				assign cell_ctrl[gi].clear = 1'b1;
				swm_cell u_cell (
					.clk      (clk),
					.ctrl     (cell_ctrl[gi]),
					.sample   (sample),
					.prev_max (sample),
					.max_q    (cell_max[gi])
				);
			end else begin : g_body
				assign cell_ctrl[gi].clear = restart;
				swm_cell u_cell (
					.clk      (clk),
					.ctrl     (cell_ctrl[gi]),
					.sample   (sample),
					.prev_max (cell_max[gi-1]),
					.max_q    (cell_max[gi])
				);
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WINDOW_RESET;
			alive_q       <= '0;
			pos_q         <= '0;
			wrapped_q     <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				window_size_q <= window_size;
			end
			if (in_fire) begin
				alive_q     <= alive_next;
				pos_q       <= pos + POS_W'(1);
				wrapped_q   <= wrapped_next;
				out_valid_q <= emit;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && emit) begin
			window_max_q <= result;
		end
	end

	assign out_valid  = out_valid_q;
	assign window_max = window_max_q;

endmodule

[hdl/swm_checker.sv]
// Port-level checker for the sliding window maximum block, bound to its top level.
// Depends on the assertion macros in sliding_window_max_top_defines.svh.
`include "sliding_window_max_top_defines.svh"

module swm_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic signed [swm_pkg::SAMPLE_W-1:0]  window_max
);

	// A result that is held keeps its value.
	`SWM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(window_max))

	// A held result blocks the input side.
	`SWM_ASSERT_NOW(a_stall_blocks_in, clk, arst_n, out_valid && !out_ready, !in_ready)

	// With no result pending the block is always ready to take a sample.
	`SWM_ASSERT_NOW(a_ready_when_empty, clk, arst_n, !out_valid, in_ready)

	// A new result appears only after an input transfer.
	`SWM_ASSERT_NOW(a_result_needs_input, clk, arst_n, $rose(out_valid), $past(in_valid && in_ready))

endmodule

bind sliding_window_max_top swm_checker u_swm_checker (.*);
